// ===== design/pvf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvf_pkg: shared types and constants for presence vote fusion
// word layouts, register indexes, reset values and reason codes
// ----------------------------------------------------------------------------
package pvf_pkg;

	localparam int unsigned MAX_WINDOW_DEF = 16;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ON_THR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_THR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NEEDED    = 3'd4;

	localparam logic [31:0] HOLD_TIME_RST = 32'd180000;
	localparam logic [15:0] ON_THR_RST    = 16'd82;
	localparam logic [15:0] OFF_THR_RST   = 16'd41;
	localparam logic [7:0]  WINDOW_RST    = 8'd5;
	localparam logic [7:0]  NEEDED_RST    = 8'd2;

	localparam logic [1:0] REASON_EMPTY  = 2'd0;
	localparam logic [1:0] REASON_MOTION = 2'd1;
	localparam logic [1:0] REASON_WANDER = 2'd2;
	localparam logic [1:0] REASON_BOTH   = 2'd3;

	typedef struct packed {
		logic [31:0] now_time;
		logic        motion_flag;
		logic [15:0] wander_sample;
	} in_word_t;

	typedef struct packed {
		logic       motion_on;
		logic       wander_on;
		logic       occupied;
		logic [1:0] reason;
	} out_word_t;

	function automatic logic [1:0] reason_code(input logic held, input logic present);
		logic [1:0] r;
		r = REASON_EMPTY;
		if (held && present) begin
			r = REASON_BOTH;
		end else if (held) begin
			r = REASON_MOTION;
		end else if (present) begin
			r = REASON_WANDER;
		end
		return r;
	endfunction

endpackage

// ===== design/presence_vote_fusion.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// presence_vote_fusion: motion hold timer fused with k-of-n wander voting
// accepts one word at a time; results go out through an output register
// backed by one holding word
// ----------------------------------------------------------------------------
// A word is accepted, a start flag is registered, then a vote count walks
// the chain of MAX_WINDOW history cells, one cell a cycle, and the result is
// registered when the count leaves the last cell. The next word is taken once
// the walk has ended and the holding word is empty, while the result may still
// wait at the output. If a result finishes while the previous one is still
// unread, it waits in the holding word and no input is taken until it has
// moved to the output. The history cells are flip-flops cleared by reset, so
// there is no clearing pass. Configuration is to be written only while the
// block is idle; the user must keep to this, the block does not enforce it.
module presence_vote_fusion #(
	parameter int unsigned MAX_WINDOW = pvf_pkg::MAX_WINDOW_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pvf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pvf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  pvf_pkg::in_word_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output pvf_pkg::out_word_t                  out_data
);
	import pvf_pkg::*;

	localparam int unsigned FW = $clog2(MAX_WINDOW + 1);
	localparam logic [7:0]    MAX8  = 8'(MAX_WINDOW);
	localparam logic [FW-1:0] MAXFW = FW'(MAX_WINDOW);
	localparam logic [FW-1:0] ONEFW = FW'(1);

	logic [31:0] hold_time_q;
	logic [15:0] on_thr_q;
	logic [15:0] off_thr_q;
	logic [7:0]  window_q;
	logic [7:0]  needed_q;

	logic          seen_q;
	logic [31:0]   last_q;
	logic [FW-1:0] slot_q;
	logic [FW-1:0] fill_q;
	logic          present_q;
	logic          walk_q;
	logic          start_q;
	logic          held_q;
	logic [15:0]   thr_q;
	logic [FW-1:0] req_q;
	logic [FW-1:0] win_q;
	out_word_t     hold_word_q;
	logic          hold_v_q;
	out_word_t     out_q;
	logic          out_v_q;

	logic          accept;
	logic          seen_n;
	logic [31:0]   last_n;
	logic [31:0]   elapsed;
	logic [FW-1:0] win_c;
	logic [FW-1:0] req_c;
	logic          done;
	logic          present_n;
	logic          out_free;
	out_word_t     res;

	logic          go_c  [MAX_WINDOW+1];
	logic [FW-1:0] cnt_c [MAX_WINDOW+1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_time_q <= HOLD_TIME_RST;
			on_thr_q    <= ON_THR_RST;
			off_thr_q   <= OFF_THR_RST;
			window_q    <= WINDOW_RST;
			needed_q    <= NEEDED_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HOLD_TIME: hold_time_q <= cfg_data;
				REG_ON_THR:    on_thr_q    <= cfg_data[15:0];
				REG_OFF_THR:   off_thr_q   <= cfg_data[15:0];
				REG_WINDOW:    window_q    <= cfg_data[7:0];
				REG_NEEDED:    needed_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign accept   = in_valid && in_ready;
	assign in_ready = !walk_q && !hold_v_q;

	// clamped window and required count
	always_comb begin
		if (window_q == 8'd0) begin
			win_c = ONEFW;
		end else if (window_q > MAX8) begin
			win_c = MAXFW;
		end else begin
			win_c = window_q[FW-1:0];
		end
		if (needed_q == 8'd0) begin
			req_c = ONEFW;
		end else if (needed_q > 8'(win_c)) begin
			req_c = win_c;
		end else begin
			req_c = needed_q[FW-1:0];
		end
	end

	assign seen_n  = seen_q || in_data.motion_flag;
	assign last_n  = in_data.motion_flag ? in_data.now_time : last_q;
	assign elapsed = in_data.now_time - last_n;

	// item control and slot wrap by repeated subtraction during the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			last_q    <= '0;
			slot_q    <= '0;
			fill_q    <= '0;
			present_q <= 1'b0;
			walk_q    <= 1'b0;
			start_q   <= 1'b0;
		end else begin
			start_q <= accept;
			if (accept) begin
				seen_q <= seen_n;
				last_q <= last_n;
				slot_q <= slot_q + ONEFW;
				walk_q <= 1'b1;
				if (fill_q < win_c) begin
					fill_q <= fill_q + ONEFW;
				end
			end else if (walk_q) begin
				if (slot_q >= win_q) begin
					slot_q <= slot_q - win_q;
				end
				if (done) begin
					walk_q    <= 1'b0;
					present_q <= present_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= seen_n && (elapsed <= hold_time_q);
			thr_q  <= present_q ? off_thr_q : on_thr_q;
			req_q  <= req_c;
			win_q  <= win_c;
		end
	end

	// vote chain
	assign go_c[0]  = start_q;
	assign cnt_c[0] = '0;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		pvf_cell #(
			.MAX_WINDOW(MAX_WINDOW),
			.INDEX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.wr_en(accept && (slot_q == FW'(i))),
			.wr_data(in_data.wander_sample),
			.threshold(thr_q),
			.fill(fill_q),
			.go_in(go_c[i]),
			.cnt_in(cnt_c[i]),
			.go_out(go_c[i+1]),
			.cnt_out(cnt_c[i+1])
		);
	end

	assign done      = go_c[MAX_WINDOW];
	assign present_n = cnt_c[MAX_WINDOW] >= req_q;

	always_comb begin
		res.motion_on = held_q;
		res.wander_on = present_n;
		res.occupied  = held_q || present_n;
		res.reason    = reason_code(held_q, present_n);
	end

	// output register with one holding word
	assign out_free = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			hold_v_q <= 1'b0;
		end else begin
			if (done) begin
				if (out_free) begin
					out_v_q <= 1'b1;
				end else begin
					hold_v_q <= 1'b1;
				end
			end else if (hold_v_q && out_free) begin
				out_v_q  <= 1'b1;
				hold_v_q <= 1'b0;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done && out_free) begin
			out_q <= res;
		end else if (done) begin
			hold_word_q <= res;
		end else if (hold_v_q && out_free) begin
			out_q <= hold_word_q;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule

// ===== design/pvf_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvf_cell: one history slot of the vote chain
// holds one stored sample and adds its vote to the count passing through
// ----------------------------------------------------------------------------
module pvf_cell #(
	parameter int unsigned MAX_WINDOW = pvf_pkg::MAX_WINDOW_DEF,
	parameter int unsigned INDEX      = 0,
	localparam int unsigned FW = $clog2(MAX_WINDOW + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [15:0]   wr_data,
	input  logic [15:0]   threshold,
	input  logic [FW-1:0] fill,
	input  logic          go_in,
	input  logic [FW-1:0] cnt_in,
	output logic          go_out,
	output logic [FW-1:0] cnt_out
);
	import pvf_pkg::*;

	localparam logic [FW-1:0] IDX = FW'(INDEX);

	logic [15:0]   sample_q;
	logic          go_s1;
	logic [FW-1:0] cnt_s1;
	logic          vote;

	assign vote = (IDX < fill) && (sample_q >= threshold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (wr_en) begin
			sample_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
		end else begin
			go_s1 <= go_in;
		end
	end

	always_ff @(posedge clk) begin
		cnt_s1 <= cnt_in + FW'(vote);
	end

	assign go_out  = go_s1;
	assign cnt_out = cnt_s1;

endmodule

// ===== design/pvf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvf_checker: port-level checks for presence vote fusion
// output word consistency and busy behavior after an accepted word
// ----------------------------------------------------------------------------
module pvf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input pvf_pkg::out_word_t out_data
);
	import pvf_pkg::*;

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// occupied follows the two flags
	a_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.occupied ==
			(out_data.motion_on || out_data.wander_on))
		else $error("occupied does not match flags");

	// reason code follows the two flags
	a_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.reason ==
			reason_code(out_data.motion_on, out_data.wander_on))
		else $error("reason code does not match flags");

	// one word at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after an accepted word");

endmodule

bind presence_vote_fusion pvf_checker u_pvf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);
